/* rtl/core/speck128_256_block_encrypt_macros.svh */
// Assertion macros for the Speck128/256 block encryption core.
`ifndef SPECK128_256_BLOCK_ENCRYPT_MACROS_SVH
`define SPECK128_256_BLOCK_ENCRYPT_MACROS_SVH

// Same-cycle implication, checked on clk_i outside of reset.
`define SPK_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked on clk_i outside of reset.
`define SPK_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

/* rtl/core/spk_pkg.sv */
// Types, constants and the round function of the Speck128/256 encryption core.
`timescale 1ns / 1ps
`default_nettype none
package spk_pkg;

  localparam int unsigned WORD_W  = 64;
  localparam int unsigned ROUND_W = 6;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] KEY_WORD0_IDX = 2'd0;
  localparam logic [CFG_IDX_W-1:0] KEY_WORD1_IDX = 2'd1;
  localparam logic [CFG_IDX_W-1:0] KEY_WORD2_IDX = 2'd2;
  localparam logic [CFG_IDX_W-1:0] KEY_WORD3_IDX = 2'd3;

  typedef logic [WORD_W-1:0] word_t;

  typedef struct packed {
    word_t plain_low;
    word_t plain_high;
  } plain_t;

  typedef struct packed {
    word_t cipher_low;
    word_t cipher_high;
  } cipher_t;

  // Block words and key schedule words as they stand between two rounds.
  typedef struct packed {
    word_t lo;
    word_t hi;
    word_t rk;
    word_t l0;
    word_t l1;
    word_t l2;
  } round_state_t;

  function automatic word_t rotr8(input word_t v);
    rotr8 = {v[7:0], v[WORD_W-1:8]};
  endfunction

  function automatic word_t rotl3(input word_t v);
    rotl3 = {v[WORD_W-4:0], v[WORD_W-1:WORD_W-3]};
  endfunction

  // One cipher round plus one key schedule round with index rnd.
  function automatic round_state_t speck_round(input round_state_t s,
                                               input logic [ROUND_W-1:0] rnd);
    round_state_t n;
    word_t        hi_n;
    word_t        nl;
    hi_n   = (rotr8(s.hi) + s.lo) ^ s.rk;
    nl     = (rotr8(s.l0) + s.rk) ^ {{(WORD_W-ROUND_W){1'b0}}, rnd};
    n.hi   = hi_n;
    n.lo   = rotl3(s.lo) ^ hi_n;
    n.rk   = rotl3(s.rk) ^ nl;
    n.l0   = s.l1;
    n.l1   = s.l2;
    n.l2   = nl;
    speck_round = n;
  endfunction

endpackage
`default_nettype wire

/* rtl/core/speck128_256_block_encrypt.sv */
// Top level of the Speck128/256 block encryption core: one round per pipeline stage.
//
// Usage: the 256-bit key is written as four 64-bit words through cfg_we_i,
// cfg_idx_i and cfg_data_i while no request is in flight; all key words reset
// to zero. A plaintext request is taken at a clock edge where in_valid_i is
// high and in_stall_o is low. Each of the ROUND_COUNT rounds, together with
// its key schedule step, sits in its own register stage. The ciphertext moves
// through the stages in order and shows on out_valid_o once it sits in the
// last one (ROUND_COUNT is 34 by default); one request can enter every cycle
// while in_stall_o is low. The stage depth is one 64-bit add and a few XORs. The
// ciphertext is held on out_data_o until a clock edge where out_stall_i is
// low. While the receiver stalls, empty stages keep filling, so new requests
// are still taken until every stage holds one; then in_stall_o rises.
// Reset empties the pipeline at once.
`timescale 1ns / 1ps
`default_nettype none
`include "speck128_256_block_encrypt_macros.svh"
module speck128_256_block_encrypt #(
  parameter int unsigned ROUND_COUNT = 34
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [spk_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire spk_pkg::word_t                 cfg_data_i,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire spk_pkg::plain_t                in_data_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output spk_pkg::cipher_t                    out_data_o
);

  spk_pkg::word_t key_word0_q, key_word1_q, key_word2_q, key_word3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_word0_q <= '0;
      key_word1_q <= '0;
      key_word2_q <= '0;
      key_word3_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        spk_pkg::KEY_WORD0_IDX: key_word0_q <= cfg_data_i;
        spk_pkg::KEY_WORD1_IDX: key_word1_q <= cfg_data_i;
        spk_pkg::KEY_WORD2_IDX: key_word2_q <= cfg_data_i;
        spk_pkg::KEY_WORD3_IDX: key_word3_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [ROUND_COUNT-1:0]       st_valid_q;
  logic [ROUND_COUNT-1:0]       st_en;
  spk_pkg::round_state_t        st_q [ROUND_COUNT];
  spk_pkg::round_state_t        st_src [ROUND_COUNT];
  logic [ROUND_COUNT-1:0]       st_valid_src;

  // A stage loads when it is empty or its content moves on this cycle.
  always_comb begin
    st_en[ROUND_COUNT-1] = !st_valid_q[ROUND_COUNT-1] || !out_stall_i;
    for (int i = ROUND_COUNT - 2; i >= 0; i--) begin
      st_en[i] = !st_valid_q[i] || st_en[i+1];
    end
  end

  always_comb begin
    st_src[0].lo       = in_data_i.plain_low;
    st_src[0].hi       = in_data_i.plain_high;
    st_src[0].rk       = key_word0_q;
    st_src[0].l0       = key_word1_q;
    st_src[0].l1       = key_word2_q;
    st_src[0].l2       = key_word3_q;
    st_valid_src[0]    = in_valid_i;
    for (int i = 1; i < ROUND_COUNT; i++) begin
      st_src[i]       = st_q[i-1];
      st_valid_src[i] = st_valid_q[i-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_valid_q <= '0;
    end else begin
      for (int i = 0; i < ROUND_COUNT; i++) begin
        if (st_en[i]) begin
          st_valid_q[i] <= st_valid_src[i];
        end
      end
    end
  end

  for (genvar r = 0; r < ROUND_COUNT; r++) begin : g_round
    always_ff @(posedge clk_i) begin
      if (st_en[r] && st_valid_src[r]) begin
        st_q[r] <= spk_pkg::speck_round(st_src[r], spk_pkg::ROUND_W'(r));
      end
    end
  end

  assign in_stall_o             = !st_en[0];
  assign out_valid_o            = st_valid_q[ROUND_COUNT-1];
  assign out_data_o.cipher_low  = st_q[ROUND_COUNT-1].lo;
  assign out_data_o.cipher_high = st_q[ROUND_COUNT-1].hi;

  `SPK_ASSERT_NXT(a_accept_fills_first, in_valid_i && !in_stall_o, st_valid_q[0])
  `SPK_ASSERT_IMP(a_stall_only_when_full, in_stall_o, (&st_valid_q) && out_stall_i)
  `SPK_ASSERT_NXT(a_stall_keeps_result, out_valid_o && out_stall_i, out_valid_o)

endmodule
`default_nettype wire

/* tb/sv/tb_top.sv */
// Self-checking testbench for the Speck128/256 block encryption pipeline.
`timescale 1ns / 1ps
module tb_top;

  localparam int unsigned NUM_ROUNDS = 34;
  localparam logic [3:0][spk_pkg::CFG_IDX_W-1:0] KEY_IDX =
    {spk_pkg::KEY_WORD3_IDX, spk_pkg::KEY_WORD2_IDX,
     spk_pkg::KEY_WORD1_IDX, spk_pkg::KEY_WORD0_IDX};

  typedef enum logic [1:0] {
    STALL_RANDOM,
    STALL_NONE,
    STALL_FILL
  } stall_mode_e;

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [spk_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  spk_pkg::word_t                cfg_data_i;
  logic                          in_valid_i;
  logic                          in_stall_o;
  spk_pkg::plain_t               in_data_i;
  logic                          out_valid_o;
  logic                          out_stall_i;
  spk_pkg::cipher_t              out_data_o;

  spk_pkg::word_t [3:0]  key_reg;
  spk_pkg::cipher_t      pending_cipher[$];
  spk_pkg::cipher_t      want;
  int                    error_count = 0;
  int                    stall_left = 0;
  bit                    idle_en = 1'b0;
  stall_mode_e           stall_mode = STALL_NONE;

  speck128_256_block_encrypt u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic spk_pkg::cipher_t encrypt_block(input spk_pkg::plain_t blk,
                                                     input spk_pkg::word_t [3:0] key);
    spk_pkg::word_t   lo, hi, rk, ka, kb, kc, nk;
    int unsigned      r;
    spk_pkg::cipher_t res;
    lo = blk.plain_low;
    hi = blk.plain_high;
    rk = key[0];
    ka = key[1];
    kb = key[2];
    kc = key[3];
    for (r = 0; r < NUM_ROUNDS; r++) begin
      hi = (((hi >> 8) | (hi << 56)) + lo) ^ rk;
      lo = ((lo << 3) | (lo >> 61)) ^ hi;
      nk = (((ka >> 8) | (ka << 56)) + rk) ^ spk_pkg::word_t'(r);
      rk = ((rk << 3) | (rk >> 61)) ^ nk;
      ka = kb;
      kb = kc;
      kc = nk;
    end
    res.cipher_low  = lo;
    res.cipher_high = hi;
    return res;
  endfunction

  function automatic spk_pkg::word_t pick_word();
    spk_pkg::word_t one_bit;
    spk_pkg::word_t w;
    one_bit = spk_pkg::word_t'(1) << $urandom_range(0, 63);
    case ($urandom_range(0, 7))
      0: w = '0;
      1: w = '1;
      2: w = one_bit;
      3: w = ~one_bit;
      default: w = {$urandom, $urandom};
    endcase
    return w;
  endfunction

  task automatic send_block(input spk_pkg::word_t lo, input spk_pkg::word_t hi);
    spk_pkg::plain_t blk;
    blk.plain_low  = lo;
    blk.plain_high = hi;
    if (idle_en && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= blk;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_cipher.push_back(encrypt_block(blk, key_reg));
  endtask

  task automatic drain_pipe();
    in_valid_i <= 1'b0;
    while (pending_cipher.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic program_key(input logic [3:0] sel, input spk_pkg::word_t [3:0] words);
    int i;
    for (i = 0; i < 4; i++) begin
      if (sel[i]) begin
        cfg_we_i   <= 1'b1;
        cfg_idx_i  <= KEY_IDX[i];
        cfg_data_i <= words[i];
        @(posedge clk_i);
        key_reg[KEY_IDX[i]] = words[i];
      end
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic test_reset_key();
    send_block('0, '0);
    send_block('1, '1);
    send_block({$urandom, $urandom}, {$urandom, $urandom});
  endtask

  task automatic test_known_vector();
    drain_pipe();
    program_key(4'hF, {64'h1f1e1d1c1b1a1918, 64'h1716151413121110,
                       64'h0f0e0d0c0b0a0908, 64'h0706050403020100});
    send_block(64'h202e72656e6f6f70, 64'h65736f6874206e49);
  endtask

  task automatic test_extremes();
    drain_pipe();
    program_key(4'hF, {4{64'hffff_ffff_ffff_ffff}});
    send_block('0, '0);
    send_block('1, '1);
    send_block(64'h1, 64'h8000_0000_0000_0000);
    send_block(64'h8000_0000_0000_0000, 64'h1);
    drain_pipe();
    program_key(4'hF, {64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa,
                       64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa});
    send_block(64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555);
    send_block('1, '0);
  endtask

  task automatic test_single_word_update();
    drain_pipe();
    program_key(4'b0100, {4{pick_word()}});
    send_block(pick_word(), pick_word());
    send_block(pick_word(), pick_word());
    drain_pipe();
    program_key(4'b0001, {4{pick_word()}});
    send_block(pick_word(), pick_word());
  endtask

  task automatic test_random_traffic();
    int                   phase;
    int                   n;
    spk_pkg::word_t [3:0] words;
    stall_mode = STALL_RANDOM;
    idle_en    = 1'b1;
    for (phase = 0; phase < 6; phase++) begin
      drain_pipe();
      for (n = 0; n < 4; n++) words[n] = pick_word();
      program_key((phase == 0) ? 4'hF : 4'($urandom_range(1, 15)), words);
      for (n = 0; n < 50; n++) send_block(pick_word(), pick_word());
    end
  endtask

  task automatic test_backpressure();
    int n;
    drain_pipe();
    idle_en    = 1'b0;
    stall_mode = STALL_FILL;
    for (n = 0; n < 40; n++) send_block(pick_word(), pick_word());
    stall_mode = STALL_RANDOM;
  endtask

  task automatic test_full_rate();
    int n;
    drain_pipe();
    idle_en    = 1'b0;
    stall_mode = STALL_NONE;
    for (n = 0; n < 40; n++) send_block(pick_word(), pick_word());
  endtask

  initial begin : receiver_stall
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      case (stall_mode)
        STALL_RANDOM: begin
          if (stall_left > 0) begin
            stall_left--;
            out_stall_i <= 1'b1;
          end else if ($urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 12) - 1;
            out_stall_i <= 1'b1;
          end else begin
            out_stall_i <= 1'b0;
          end
        end
        STALL_FILL: out_stall_i <= !in_stall_o;
        default: out_stall_i <= 1'b0;
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_cipher.size() == 0) begin
        $error("cipher result with no request pending: %h", out_data_o);
        error_count++;
      end else begin
        want = pending_cipher.pop_front();
        if (out_data_o.cipher_low !== want.cipher_low) begin
          $error("cipher_low: expected %h, actual %h", want.cipher_low,
                 out_data_o.cipher_low);
          error_count++;
        end
        if (out_data_o.cipher_high !== want.cipher_high) begin
          $error("cipher_high: expected %h, actual %h", want.cipher_high,
                 out_data_o.cipher_high);
          error_count++;
        end
      end
    end
  end

  initial begin : main_sequence
    key_reg     = '0;
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= spk_pkg::KEY_WORD0_IDX;
    cfg_data_i  <= '0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_key();
    test_known_vector();
    test_extremes();
    test_single_word_update();
    test_random_traffic();
    test_backpressure();
    test_full_rate();
    drain_pipe();
    repeat (NUM_ROUNDS + 6) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin : watchdog
    #1000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/spk_pkg.sv
rtl/core/speck128_256_block_encrypt.sv
tb/sv/tb_top.sv
